### hdl/bpa_pkg.sv
// Package for the buddy page allocator: payload structs, state and
// datapath operation codes, controller/datapath link structs.
// No dependencies.
`timescale 1ns / 1ps

package bpa_pkg;

	localparam int OW = 5;	// level width wide enough for every legal order count

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_NOMEM = 1'b1;

	typedef struct packed {
		logic        command;
		logic [3:0]  block_order;
		logic [14:0] page_number;
	} bpa_req_t;

	typedef struct packed {
		logic        status;
		logic [14:0] result_page;
		logic [3:0]  result_order;
	} bpa_rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_FIND,
		S_A_POP,
		S_A_SPLIT,
		S_F_CHECK,
		S_F_MATE,
		S_F_WALK,
		S_F_LINK
	} bpa_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_A_POP_RD,
		OP_A_POP,
		OP_A_SPLIT,
		OP_A_FIN,
		OP_A_NOMEM,
		OP_F_MATE_RD,
		OP_W_INIT,
		OP_W_RD,
		OP_W_STEP,
		OP_W_UNLINK,
		OP_MERGE,
		OP_F_PUSH
	} bpa_op_t;

	typedef struct packed {
		bpa_op_t op;
	} bpa_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_free;
		logic found;
		logic split_more;
		logic below_top;
		logic mate_match;
		logic walk_ok;
		logic cur_hit;
	} bpa_stat_t;

endpackage

### hdl/bpa_ctrl.sv
// Controller for the buddy page allocator: sequences clear, allocate
// and free operations. Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bpa_pkg::bpa_stat_t stat,
	output bpa_pkg::bpa_cmd_t  cmd,
	output logic             busy
);
	import bpa_pkg::*;

	bpa_state_t state_q, state_nx;

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_CLEAR:   if (stat.clear_last) state_nx = S_IDLE;
			S_IDLE:    if (start) state_nx = stat.is_free ? S_F_CHECK : S_A_FIND;
			S_A_FIND:  state_nx = stat.found ? S_A_POP : S_IDLE;
			S_A_POP:   state_nx = S_A_SPLIT;
			S_A_SPLIT: if (!stat.split_more) state_nx = S_IDLE;
			S_F_CHECK: state_nx = stat.below_top ? S_F_MATE : S_IDLE;
			S_F_MATE:  state_nx = stat.mate_match ? S_F_WALK : S_IDLE;
			S_F_WALK:  state_nx = stat.walk_ok ? S_F_LINK : S_F_CHECK;
			S_F_LINK:  state_nx = stat.cur_hit ? S_F_CHECK : S_F_WALK;
			default:   state_nx = S_IDLE;
		endcase
	end

	// issue datapath operation
	always_comb begin
		cmd.op = OP_NONE;
		busy = 1'b1;
		unique case (state_q)
			S_CLEAR:   cmd.op = OP_CLEAR;
			S_IDLE: begin
				busy = 1'b0;
				if (start) cmd.op = OP_LOAD;
			end
			S_A_FIND:  cmd.op = stat.found ? OP_A_POP_RD : OP_A_NOMEM;
			S_A_POP:   cmd.op = OP_A_POP;
			S_A_SPLIT: cmd.op = stat.split_more ? OP_A_SPLIT : OP_A_FIN;
			S_F_CHECK: cmd.op = stat.below_top ? OP_F_MATE_RD : OP_F_PUSH;
			S_F_MATE:  cmd.op = stat.mate_match ? OP_W_INIT : OP_F_PUSH;
			S_F_WALK:  cmd.op = stat.walk_ok ? OP_W_RD : OP_MERGE;
			S_F_LINK:  cmd.op = stat.cur_hit ? OP_W_UNLINK : OP_W_STEP;
			default:   cmd.op = OP_NONE;
		endcase
	end

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted transfer did not raise busy");
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_CLEAR |=> state_q != S_CLEAR) else $error("clear pass reentered");
	a_link_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_F_LINK |-> $past(state_q) == S_F_WALK)
		else $error("link check without walk read");
`endif

endmodule

### hdl/bpa_dpath.sv
// Datapath for the buddy page allocator: list heads, link and page
// info memories, walk registers and result register. Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_dpath #(
	parameter int ORDER_COUNT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bpa_pkg::bpa_cmd_t  cmd,
	input  bpa_pkg::bpa_req_t  request,
	output bpa_pkg::bpa_stat_t stat,
	output bpa_pkg::bpa_rsp_t  response,
	output logic               done
);
	import bpa_pkg::*;

	localparam int PW = ORDER_COUNT - 1;
	localparam int LW = $clog2(ORDER_COUNT);
	localparam int PAGES = 1 << PW;
	localparam logic [PW:0] POOL = {1'b1, {PW{1'b0}}};
	localparam logic [LW-1:0] TOP = LW'(ORDER_COUNT - 1);

	// page info: free mark and order; link: valid flag and next page
	logic [LW:0] info_mem [PAGES];
	logic [PW:0] link_mem [PAGES];
	logic [LW:0] info_rd_q;
	logic [PW:0] link_rd_q;

	logic [PW-1:0] heads_q [ORDER_COUNT];
	logic [ORDER_COUNT-1:0] hv_q;
	logic cmd_q, has_before_q, cur_ok_q, done_q;
	logic [3:0] req_q;
	logic [LW-1:0] lvl_q;
	logic [PW-1:0] blk_q, cur_q, before_q, clr_q;
	logic [PW:0] steps_q;
	bpa_rsp_t rsp_q;

	logic [LW-1:0] found_lvl, lvl_dn, load_lvl;
	logic found;
	logic [PW-1:0] half, mate;
	logic [PW+14:0] pg_in, pg_out;

	// find smallest non-empty list at or above the request
	always_comb begin
		found = 1'b0;
		found_lvl = '0;
		for (int l = ORDER_COUNT - 1; l >= 0; l--) begin
			if (hv_q[l] && OW'(l) >= OW'(req_q)) begin
				found = 1'b1;
				found_lvl = LW'(l);
			end
		end
	end

	assign lvl_dn = lvl_q - LW'(1);
	assign half = blk_q + (PW'(1) << lvl_dn);
	assign mate = blk_q ^ (PW'(1) << lvl_q);
	assign pg_in = {{PW{1'b0}}, request.page_number};
	assign pg_out = {15'b0, blk_q};
	assign load_lvl = (OW'(request.block_order) > OW'(ORDER_COUNT - 1)) ? TOP
		: LW'(request.block_order);

	assign stat.clear_last = (clr_q == {PW{1'b1}});
	assign stat.is_free = request.command;
	assign stat.found = found;
	assign stat.split_more = OW'(lvl_q) > OW'(req_q);
	assign stat.below_top = lvl_q < TOP;
	assign stat.mate_match = info_rd_q[LW] && (info_rd_q[LW-1:0] == lvl_q);
	assign stat.walk_ok = cur_ok_q && (steps_q <= POOL);
	assign stat.cur_hit = (cur_q == mate);

	// memory writes and registered reads
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CLEAR: begin
				info_mem[clr_q] <= (clr_q == '0) ? {1'b1, TOP} : '0;
				link_mem[clr_q] <= '0;
			end
			OP_A_POP_RD: link_rd_q <= link_mem[heads_q[found_lvl]];
			OP_A_SPLIT: begin
				info_mem[half] <= {1'b1, lvl_dn};
				link_mem[half] <= {hv_q[lvl_dn], heads_q[lvl_dn]};
			end
			OP_A_FIN: begin
				info_mem[blk_q] <= {1'b0, LW'(req_q)};
				link_mem[blk_q] <= '0;
			end
			OP_F_MATE_RD: info_rd_q <= info_mem[mate];
			OP_W_RD: link_rd_q <= link_mem[cur_q];
			OP_W_UNLINK: if (has_before_q) link_mem[before_q] <= link_rd_q;
			OP_F_PUSH: begin
				info_mem[blk_q] <= {1'b1, lvl_q};
				link_mem[blk_q] <= {hv_q[lvl_q], heads_q[lvl_q]};
			end
			default: ;
		endcase
	end

	// registers driven by datapath operations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < ORDER_COUNT; l++) heads_q[l] <= '0;
			hv_q <= {1'b1, {(ORDER_COUNT-1){1'b0}}};
			cmd_q <= CMD_ALLOC;
			req_q <= '0;
			lvl_q <= '0;
			blk_q <= '0;
			cur_q <= '0;
			before_q <= '0;
			has_before_q <= 1'b0;
			cur_ok_q <= 1'b0;
			steps_q <= '0;
			clr_q <= '0;
			rsp_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (cmd.op)
				OP_CLEAR: clr_q <= clr_q + PW'(1);
				OP_LOAD: begin
					cmd_q <= request.command;
					req_q <= request.block_order;
					lvl_q <= load_lvl;
					blk_q <= pg_in[PW-1:0];
				end
				OP_A_POP_RD: begin
					lvl_q <= found_lvl;
					blk_q <= heads_q[found_lvl];
				end
				OP_A_POP: begin
					heads_q[lvl_q] <= link_rd_q[PW-1:0];
					hv_q[lvl_q] <= link_rd_q[PW];
				end
				OP_A_SPLIT: begin
					lvl_q <= lvl_dn;
					heads_q[lvl_dn] <= half;
					hv_q[lvl_dn] <= 1'b1;
				end
				OP_A_FIN: begin
					rsp_q <= {STATUS_OK, pg_out[14:0], req_q};
					done_q <= 1'b1;
				end
				OP_A_NOMEM: begin
					rsp_q <= {STATUS_NOMEM, 15'd0, 4'd0};
					done_q <= 1'b1;
				end
				OP_W_INIT: begin
					cur_q <= heads_q[lvl_q];
					cur_ok_q <= hv_q[lvl_q];
					has_before_q <= 1'b0;
					steps_q <= '0;
				end
				OP_W_STEP: begin
					before_q <= cur_q;
					has_before_q <= 1'b1;
					cur_q <= link_rd_q[PW-1:0];
					cur_ok_q <= link_rd_q[PW];
					steps_q <= steps_q + (PW+1)'(1);
				end
				OP_W_UNLINK: begin
					if (!has_before_q) begin
						heads_q[lvl_q] <= link_rd_q[PW-1:0];
						hv_q[lvl_q] <= link_rd_q[PW];
					end
					blk_q <= blk_q & mate;
					lvl_q <= lvl_q + LW'(1);
				end
				OP_MERGE: begin
					blk_q <= blk_q & mate;
					lvl_q <= lvl_q + LW'(1);
				end
				OP_F_PUSH: begin
					heads_q[lvl_q] <= blk_q;
					hv_q[lvl_q] <= 1'b1;
					rsp_q <= {STATUS_OK, pg_out[14:0], 4'(OW'(lvl_q))};
					done_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign response = rsp_q;
	assign done = done_q;

`ifndef SYNTHESIS
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe held two cycles");
	a_nomem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.status |-> rsp_q.result_page == 15'd0 && rsp_q.result_order == 4'd0)
		else $error("no-memory result carries data");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= POOL + (PW+1)'(1)) else $error("walk step count overran");
	a_free_no_alloc_ops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_A_FIN |-> cmd_q == CMD_ALLOC) else $error("allocate finish during free");
`endif

endmodule

### hdl/buddy_page_allocator_unit.sv
// Buddy page allocator over a pool of 2^(ORDER_COUNT-1) pages.
//
// Request channel: drive request and raise start; the transfer happens at
// the clock edge where start is high and busy is low. request.command
// selects allocate or free, block_order the order, page_number the first
// page of a freed block.
// Result channel: done is high for exactly one cycle with response valid;
// the receiver takes it in that cycle and cannot stall it.
// An allocate searches for the smallest non-empty list at or above the
// requested order, pops its head and splits the block down to that order;
// a failed allocate ends after the search. A free checks the buddy at each
// order below the top, walks that order's list to unlink it and merges,
// and pushes the block once the buddy does not match or the top is reached.
// Items are handled one at a time: busy stays high from the accepting
// edge until the cycle in which done rises.
// After reset the block runs a clearing pass over every entry of the page
// memories with busy high, then holds the whole pool as one free block
// at page 0 of the top order.
// Depends on bpa_pkg, bpa_ctrl and bpa_dpath.
`timescale 1ns / 1ps

module buddy_page_allocator_unit #(
	parameter int ORDER_COUNT = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bpa_pkg::bpa_req_t request,
	output bpa_pkg::bpa_rsp_t response,
	output logic              done
);
	import bpa_pkg::*;

	bpa_cmd_t cmd;
	bpa_stat_t stat;

	// sequence operations
	bpa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.stat(stat),
		.cmd(cmd),
		.busy(busy)
	);

	// hold lists, memories and results
	bpa_dpath #(.ORDER_COUNT(ORDER_COUNT)) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.request(request),
		.stat(stat),
		.response(response),
		.done(done)
	);

endmodule
